### hdl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/sbta_pkg.sv
package sbta_pkg;

  localparam int ADDR_W = 12;
  localparam int LEN_W  = 13;
  localparam int STAT_W = 3;

  // heap size is tied to the fixed address and length widths of the beats
  localparam int HEAP_BYTES = 4096;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_NOSPACE  = 3'd2;
  localparam status_t ST_BADSIZE  = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [2:0] idx_op_t;

  localparam idx_op_t IDX_HOLD = 3'd0;
  localparam idx_op_t IDX_ZERO = 3'd1;
  localparam idx_op_t IDX_USED = 3'd2;
  localparam idx_op_t IDX_DEC  = 3'd3;
  localparam idx_op_t IDX_INC  = 3'd4;

  typedef logic [1:0] rd_sel_t;

  localparam rd_sel_t RD_BELOW = 2'd0;
  localparam rd_sel_t RD_AT    = 2'd1;
  localparam rd_sel_t RD_ABOVE = 2'd2;

  typedef struct packed {
    logic    load_req;
    idx_op_t idx_op;
    rd_sel_t rd_sel;
    logic    mem_rd;
    logic    mem_wr;
    logic    wr_insert;
    logic    upper_heap;
    logic    upper_take;
    logic    mark_pos;
    logic    pos_clear;
    logic    used_inc;
    logic    used_dec;
    logic    res_load;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic used_zero;
    logic used_full;
    logic size_bad;
    logic idx_zero;
    logic idx_at_pos;
    logic idx_at_used;
    logic idx_last;
    logic fits;
    logic match;
  } dp_stat_t;

endpackage

### hdl/sbta_if.sv
interface sbta_req_if
  import sbta_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [LEN_W-1:0]  request_bytes;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output opcode, output request_bytes,
                  output free_address, input ready);
  modport sink   (input valid, input opcode, input request_bytes,
                  input free_address, output ready);
endinterface

interface sbta_rsp_if
  import sbta_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;
  status_t           status;

  modport source (output valid, output block_address, output status, input ready);
  modport sink   (input valid, input block_address, input status, output ready);
endinterface

### hdl/sbta_ctrl.sv
module sbta_ctrl
  import sbta_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_EV  = 4'd3;
  localparam logic [3:0] S_UP    = 4'd4;
  localparam logic [3:0] S_UPW   = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_F_RD  = 4'd7;
  localparam logic [3:0] S_F_EV  = 4'd8;
  localparam logic [3:0] S_DN    = 4'd9;
  localparam logic [3:0] S_DNW   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state, state_next;
  status_t    res_code, res_code_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    cmd           = '0;
    cmd.idx_op    = IDX_HOLD;
    cmd.rd_sel    = RD_AT;
    cmd.res_status = res_code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_free) begin
          cmd.idx_op = IDX_ZERO;
          state_next = S_F_RD;
        end else if (stat.used_full) begin
          res_code_next = ST_FULL;
          state_next    = S_OUT;
        end else if (stat.size_bad) begin
          res_code_next = ST_BADSIZE;
          state_next    = S_OUT;
        end else if (stat.used_zero) begin
          cmd.pos_clear = 1'b1;
          state_next    = S_INS;
        end else begin
          cmd.idx_op     = IDX_USED;
          cmd.upper_heap = 1'b1;
          state_next     = S_A_RD;
        end
      end
      // scan downward, gap above entry idx-1
      S_A_RD: begin
        if (stat.idx_zero) begin
          res_code_next = ST_NOSPACE;
          state_next    = S_OUT;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RD_BELOW;
          state_next = S_A_EV;
        end
      end
      S_A_EV: begin
        if (stat.fits) begin
          cmd.mark_pos = 1'b1;
          cmd.idx_op   = IDX_USED;
          state_next   = S_UP;
        end else begin
          cmd.upper_take = 1'b1;
          cmd.idx_op     = IDX_DEC;
          state_next     = S_A_RD;
        end
      end
      // open a hole at the insert position
      S_UP: begin
        if (stat.idx_at_pos) begin
          state_next = S_INS;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RD_BELOW;
          state_next = S_UPW;
        end
      end
      S_UPW: begin
        cmd.mem_wr = 1'b1;
        cmd.idx_op = IDX_DEC;
        state_next = S_UP;
      end
      S_INS: begin
        cmd.mem_wr    = 1'b1;
        cmd.wr_insert = 1'b1;
        cmd.used_inc  = 1'b1;
        res_code_next = ST_OK;
        state_next    = S_OUT;
      end
      S_F_RD: begin
        if (stat.idx_at_used) begin
          res_code_next = ST_NOTFOUND;
          state_next    = S_OUT;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RD_AT;
          state_next = S_F_EV;
        end
      end
      S_F_EV: begin
        if (stat.match) begin
          state_next = S_DN;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_F_RD;
        end
      end
      // close the hole left by the freed entry
      S_DN: begin
        if (stat.idx_last) begin
          cmd.used_dec  = 1'b1;
          res_code_next = ST_OK;
          state_next    = S_OUT;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RD_ABOVE;
          state_next = S_DNW;
        end
      end
      S_DNW: begin
        cmd.mem_wr = 1'b1;
        cmd.idx_op = IDX_INC;
        state_next = S_DN;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.res_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_code  <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_code  <= res_code_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hdl/sbta_dpath.sv
module sbta_dpath
  import sbta_pkg::*;
#(
  parameter int MAX_BLOCKS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              opcode,
  input  logic [LEN_W-1:0]  request_bytes,
  input  logic [ADDR_W-1:0] free_address,
  output logic [ADDR_W-1:0] block_address,
  output status_t           status
);

  localparam int AW = $clog2(HEAP_BYTES + 1);
  localparam int W  = (AW > LEN_W) ? AW : LEN_W;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);

  localparam logic [W-1:0]  HEAP_END = W'(HEAP_BYTES);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BLOCKS);

  logic [2*W-1:0] mem [MAX_BLOCKS];
  logic [2*W-1:0] rd_data;

  logic           op_q;
  logic [W-1:0]   req_q;
  logic [W-1:0]   faddr_q;
  logic [CW-1:0]  used;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  pos;
  logic [W-1:0]   upper;
  logic [W-1:0]   found_end;

  logic [CW-1:0]  rd_ptr;
  logic [CW-1:0]  wr_ptr;
  logic [2*W-1:0] wr_data;
  logic [W-1:0]   rd_start;
  logic [W-1:0]   rd_len;
  logic [W-1:0]   blk_end;

  assign rd_start = rd_data[2*W-1:W];
  assign rd_len   = rd_data[W-1:0];
  assign blk_end  = rd_start + rd_len;

  always_comb begin
    case (cmd.rd_sel)
      RD_BELOW: rd_ptr = idx - CW'(1);
      RD_ABOVE: rd_ptr = idx + CW'(1);
      default:  rd_ptr = idx;
    endcase
  end

  assign wr_ptr  = cmd.wr_insert ? pos : idx;
  assign wr_data = cmd.wr_insert ? {found_end, req_q} : rd_data;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_ptr[IW-1:0]] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[rd_ptr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q    <= opcode;
      req_q   <= W'(request_bytes);
      faddr_q <= W'(free_address);
    end
    case (cmd.idx_op)
      IDX_ZERO: idx <= '0;
      IDX_USED: idx <= used;
      IDX_DEC:  idx <= idx - CW'(1);
      IDX_INC:  idx <= idx + CW'(1);
      default:  idx <= idx;
    endcase
    if (cmd.upper_heap) begin
      upper <= HEAP_END;
    end else if (cmd.upper_take) begin
      upper <= rd_start;
    end
    if (cmd.pos_clear) begin
      pos       <= '0;
      found_end <= '0;
    end else if (cmd.mark_pos) begin
      pos       <= idx;
      found_end <= blk_end;
    end
    if (cmd.res_load) begin
      status <= cmd.res_status;
      block_address <= (cmd.res_status == ST_OK && op_q == OP_ALLOC) ?
                       found_end[ADDR_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.used_inc) begin
      used <= used + CW'(1);
    end else if (cmd.used_dec) begin
      used <= used - CW'(1);
    end
  end

  always_comb begin
    stat.is_free     = (op_q == OP_FREE);
    stat.used_zero   = (used == '0);
    stat.used_full   = (used == FULL_CNT);
    stat.size_bad    = (req_q == '0) || (req_q > HEAP_END);
    stat.idx_zero    = (idx == '0);
    stat.idx_at_pos  = (idx == pos);
    stat.idx_at_used = (idx == used);
    stat.idx_last    = ((idx + CW'(1)) == used);
    stat.fits        = (upper >= blk_end) && ((upper - blk_end) >= req_q);
    stat.match       = (rd_start == faddr_q);
  end

endmodule

### hdl/sorted_block_table_allocator.sv
// channel | dir | beat fields
// req     | in  | opcode, request_bytes, free_address
// rsp     | out | block_address, status
//
// one request at a time; the table sits in a memory with a registered read,
// so each entry read or moved takes a read state and then a write or evaluate state
// allocate scans downward for a gap, then shifts entries up to open a hole;
// free scans upward for a match, then shifts down; full or bad size ends at the check
// reset empties the table through the entry count alone, no clearing pass
// a result waits in the output register while the next request is taken
`include "assert_macros.svh"

module sorted_block_table_allocator
  import sbta_pkg::*;
#(
  parameter int MAX_BLOCKS = 16
) (
  input logic       clk,
  input logic       rst,
  sbta_req_if.sink  req,
  sbta_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sbta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbta_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (req.opcode),
    .request_bytes (req.request_bytes),
    .free_address  (req.free_address),
    .block_address (rsp.block_address),
    .status        (rsp.status)
  );

  `ASSERT_IMPLIES(a_no_write_idle, clk, rst, req.ready, !cmd.mem_wr)
  `ASSERT_IMPLIES(a_rd_wr_apart, clk, rst, cmd.mem_rd, !cmd.mem_wr)
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.res_load, !rsp.valid || rsp.ready)
  `ASSERT_NEXT(a_result_shown, clk, rst, cmd.res_load, rsp.valid)

endmodule
